/* rtl/ssc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ssc_pkg
// shared constants, types and the cordic arctangent table for the
// scan segment centroid core
// ----------------------------------------------------------------------------
package ssc_pkg;

    localparam int MAX_SAMPLES  = 1024;
    localparam int CORDIC_STEPS = 14;
    localparam int CORDIC_W     = 34;
    localparam int ITER_W       = $clog2(CORDIC_STEPS);
    localparam int SUM_W        = 28;
    localparam int CNT_W        = 11;
    localparam int IDX_W        = 11;
    localparam int MEAN_W       = 17;
    localparam int DIV_W        = 28;
    localparam int DIV_CNT_W    = $clog2(DIV_W);

    localparam logic signed [CORDIC_W-1:0] CORDIC_START = 34'sd652032874;
    localparam logic [15:0] ANGLE_STEP_RESET = 16'd91;

    // register byte offsets, bit 2 of paddr selects the word
    localparam logic REG_ANGLE_STEP = 1'b0;

    // arctangent of 2^-i in 1/65536 turn
    function automatic logic signed [15:0] atan_turn(input logic [ITER_W-1:0] i);
        logic signed [15:0] r;
        unique case (i)
            4'd0:    r = 16'sd8192;
            4'd1:    r = 16'sd4836;
            4'd2:    r = 16'sd2555;
            4'd3:    r = 16'sd1297;
            4'd4:    r = 16'sd651;
            4'd5:    r = 16'sd326;
            4'd6:    r = 16'sd163;
            4'd7:    r = 16'sd81;
            4'd8:    r = 16'sd41;
            4'd9:    r = 16'sd20;
            4'd10:   r = 16'sd10;
            4'd11:   r = 16'sd5;
            4'd12:   r = 16'sd3;
            4'd13:   r = 16'sd1;
            default: r = 16'sd0;
        endcase
        return r;
    endfunction

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_TRIG  = 9'b000000010,
        ST_MULX  = 9'b000000100,
        ST_MULY  = 9'b000001000,
        ST_ACCY  = 9'b000010000,
        ST_CLOSE = 9'b000100000,
        ST_DIVX  = 9'b001000000,
        ST_DIVY  = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    // handshake with an iterative unit
    typedef struct packed {
        logic start;
    } unit_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_rsp_t;

endpackage
`default_nettype wire

/* rtl/ssc_cordic.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ssc_cordic
// rotation-mode cordic, one micro-rotation per cycle, q1.15 cos and sin out
// ----------------------------------------------------------------------------
module ssc_cordic
    import ssc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire unit_req_t          req,
    input  wire logic [15:0]        angle,
    output unit_rsp_t               rsp,
    output logic signed [15:0]      cos_q15,
    output logic signed [15:0]      sin_q15
);

    logic signed [CORDIC_W-1:0] x_reg, x_next;
    logic signed [CORDIC_W-1:0] y_reg, y_next;
    logic signed [15:0]         z_reg, z_next;
    logic [1:0]                 quad_reg, quad_next;
    logic [ITER_W-1:0]          iter_reg, iter_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;

    logic signed [CORDIC_W-1:0] dx, dy;
    logic signed [15:0]         cc, ss;

    // round to q1.15 with clamp
    function automatic logic signed [15:0] to_q15(input logic signed [CORDIC_W-1:0] v);
        logic signed [CORDIC_W-1:0] r;
        logic signed [15:0]         q;
        r = (v + 34'sd16384) >>> 15;
        if (r > 34'sd32767)       q = 16'sd32767;
        else if (r < -34'sd32768) q = -16'sd32768;
        else                      q = r[15:0];
        return q;
    endfunction

    always_comb
    begin
        dx = y_reg >>> iter_reg;
        dy = x_reg >>> iter_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        quad_next = quad_reg;
        iter_next = iter_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            x_next    = CORDIC_START;
            y_next    = '0;
            z_next    = {2'b00, angle[13:0]};
            quad_next = angle[15:14];
            iter_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!z_reg[15])
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - atan_turn(iter_reg);
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + atan_turn(iter_reg);
            end
            iter_next = iter_reg + 1'b1;
            if (iter_reg == ITER_W'(CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        quad_reg <= quad_next;
        iter_reg <= iter_next;
    end

    // quadrant fold by swap and negate
    always_comb
    begin
        cc = to_q15(x_reg);
        ss = to_q15(y_reg);
        unique case (quad_reg)
            2'd0:    begin cos_q15 = cc;  sin_q15 = ss;  end
            2'd1:    begin cos_q15 = -ss; sin_q15 = cc;  end
            2'd2:    begin cos_q15 = -cc; sin_q15 = -ss; end
            default: begin cos_q15 = ss;  sin_q15 = -cc; end
        endcase
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;

endmodule
`default_nettype wire

/* rtl/ssc_divider.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ssc_divider
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ssc_divider
    import ssc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire unit_req_t          req,
    input  wire logic [DIV_W-1:0]   dividend,
    input  wire logic [CNT_W-1:0]   divisor,
    output unit_rsp_t               rsp,
    output logic [DIV_W-1:0]        quotient
);

    logic [DIV_W-1:0]     q_reg, q_next;
    logic [CNT_W:0]       rem_reg, rem_next;
    logic [CNT_W-1:0]     dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [CNT_W:0]       shifted;

    always_comb
    begin
        shifted   = {rem_reg[CNT_W-1:0], q_reg[DIV_W-1]};
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            q_next    = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, dvs_reg})
            begin
                rem_next = shifted - {1'b0, dvs_reg};
                q_next   = {q_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                q_next   = {q_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
    end

    assign quotient = q_reg;
    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;

endmodule
`default_nettype wire

/* rtl/scan_segment_centroid_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// scan_segment_centroid_core
// groups valid laser range samples into runs and reports each run's centroid
// ----------------------------------------------------------------------------
// sequence: a point sample runs the cordic (start, micro-rotations, done),
//   two shared multiplies, accumulate and the close check; a run-closing
//   sample adds the x and y divides and an output step before the result word
//   shows
// throughput: one sample at a time, accepted only in idle; a result word
//   stuck in the output register holds the core until it leaves
// reset: rst_n is asynchronous active low; clears sums, counts, index and
//   handshake state, angle_step returns to 91
module scan_segment_centroid_core
    import ssc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input sample stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // [15:0] range_mm
    input  wire logic [0:0]  s_axis_tuser,  // [0] range_valid
    input  wire logic        s_axis_tlast,  // last_in_scan
    // centroid stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,  // [16:0] mean_x, [33:17] mean_y,
                                            // [44:34] point_count, rest zero
    output logic             m_axis_tlast,  // closes_scan
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    state_t state_reg, state_next;

    logic [15:0]              angle_step_reg, angle_step_next;
    logic [IDX_W-1:0]         index_reg, index_next;
    logic signed [SUM_W-1:0]  sum_x_reg, sum_x_next;
    logic signed [SUM_W-1:0]  sum_y_reg, sum_y_next;
    logic [CNT_W-1:0]         count_reg, count_next;

    // latched sample
    logic [15:0]              range_reg, range_next;
    logic                     valid_reg, valid_next;
    logic                     last_reg, last_next;
    logic [15:0]              angle_reg, angle_next;

    logic signed [32:0]       prod_reg, prod_next;
    logic signed [MEAN_W-1:0] qx_reg, qx_next;

    logic                     ovalid_reg, ovalid_next;
    logic [47:0]              odata_reg, odata_next;
    logic                     olast_reg, olast_next;

    logic                     in_fire;
    logic                     cfg_write;
    logic [26:0]              angle_prod;

    // shared multiplier operand
    logic signed [15:0]       mul_trig;
    logic signed [33:0]       round_sum;
    logic signed [17:0]       point;

    // shared divider operand
    logic signed [SUM_W-1:0]  div_src;
    logic [DIV_W-1:0]         div_mag;
    logic [DIV_W-1:0]         div_dividend;
    logic signed [DIV_W-1:0]  signed_q;
    logic signed [DIV_W-1:0]  div_neg_src;

    unit_req_t                trig_req, div_req;
    unit_rsp_t                trig_rsp, div_rsp;
    logic signed [15:0]       cos_q15, sin_q15;
    logic [DIV_W-1:0]         quotient;

    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign angle_prod = angle_step_reg * index_reg;

    ssc_cordic u_cordic
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (trig_req),
        .angle   (angle_reg),
        .rsp     (trig_rsp),
        .cos_q15 (cos_q15),
        .sin_q15 (sin_q15)
    );

    ssc_divider u_divider
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (div_dividend),
        .divisor  (count_reg),
        .rsp      (div_rsp),
        .quotient (quotient)
    );

    // point coordinate from the registered product, rounded to mm
    assign round_sum = {prod_reg[32], prod_reg} + 34'sd16384;
    assign point     = round_sum[32:15];
    assign mul_trig  = (state_reg == ST_MULX) ? cos_q15 : sin_q15;

    // divider takes y while the x quotient is being captured
    assign div_src      = (state_reg == ST_CLOSE) ? sum_x_reg : sum_y_reg;
    assign div_mag      = div_src[SUM_W-1] ? DIV_W'(-div_src) : DIV_W'(div_src);
    assign div_dividend = div_mag + DIV_W'(count_reg >> 1);
    assign div_neg_src  = (state_reg == ST_DIVX) ? sum_x_reg : sum_y_reg;
    assign signed_q     = div_neg_src[SUM_W-1] ? -$signed(quotient) : $signed(quotient);

    always_comb
    begin
        state_next      = state_reg;
        angle_step_next = angle_step_reg;
        index_next      = index_reg;
        sum_x_next      = sum_x_reg;
        sum_y_next      = sum_y_reg;
        count_next      = count_reg;
        range_next      = range_reg;
        valid_next      = valid_reg;
        last_next       = last_reg;
        angle_next      = angle_reg;
        prod_next       = prod_reg;
        qx_next         = qx_reg;
        ovalid_next     = ovalid_reg;
        odata_next      = odata_reg;
        olast_next      = olast_reg;
        trig_req.start  = 1'b0;
        div_req.start   = 1'b0;

        if (cfg_write && paddr[2] == REG_ANGLE_STEP)
            angle_step_next = pwdata[15:0];

        if (ovalid_reg && m_axis_tready)
            ovalid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    range_next = s_axis_tdata;
                    valid_next = s_axis_tuser[0];
                    last_next  = s_axis_tlast;
                    angle_next = angle_prod[15:0];
                    index_next = s_axis_tlast ? '0 : index_reg + 1'b1;
                    if (s_axis_tuser[0] && count_reg < CNT_W'(MAX_SAMPLES))
                        state_next = ST_TRIG;
                    else
                        state_next = ST_CLOSE;
                end
            end
            ST_TRIG:
            begin
                // angle_reg was loaded on the previous edge
                if (!trig_rsp.busy && !trig_rsp.done)
                    trig_req.start = 1'b1;
                if (trig_rsp.done)
                    state_next = ST_MULX;
            end
            ST_MULX:
            begin
                prod_next  = $signed({1'b0, range_reg}) * mul_trig;
                state_next = ST_MULY;
            end
            ST_MULY:
            begin
                sum_x_next = sum_x_reg + SUM_W'(point);
                prod_next  = $signed({1'b0, range_reg}) * mul_trig;
                state_next = ST_ACCY;
            end
            ST_ACCY:
            begin
                sum_y_next = sum_y_reg + SUM_W'(point);
                count_next = count_reg + 1'b1;
                state_next = ST_CLOSE;
            end
            ST_CLOSE:
            begin
                if ((!valid_reg || last_reg) && count_reg != '0)
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIVX;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_DIVX:
            begin
                if (div_rsp.done)
                begin
                    qx_next       = signed_q[MEAN_W-1:0];
                    div_req.start = 1'b1;
                    state_next    = ST_DIVY;
                end
            end
            ST_DIVY:
            begin
                if (div_rsp.done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // hand the word to the output register once it is free,
                // the y quotient stays put in the idle divider meanwhile
                if (!ovalid_reg || m_axis_tready)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = {3'b000, count_reg, signed_q[MEAN_W-1:0], qx_reg};
                    olast_next  = last_reg;
                    sum_x_next  = '0;
                    sum_y_next  = '0;
                    count_next  = '0;
                    state_next  = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            angle_step_reg <= ANGLE_STEP_RESET;
            index_reg      <= '0;
            sum_x_reg      <= '0;
            sum_y_reg      <= '0;
            count_reg      <= '0;
            ovalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            angle_step_reg <= angle_step_next;
            index_reg      <= index_next;
            sum_x_reg      <= sum_x_next;
            sum_y_reg      <= sum_y_next;
            count_reg      <= count_next;
            ovalid_reg     <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        range_reg <= range_next;
        valid_reg <= valid_next;
        last_reg  <= last_next;
        angle_reg <= angle_next;
        prod_reg  <= prod_next;
        qx_reg    <= qx_next;
        odata_reg <= odata_next;
        olast_reg <= olast_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tlast  = olast_reg;
    assign pready        = 1'b1;
    assign prdata        = (paddr[2] == REG_ANGLE_STEP) ? {16'h0000, angle_step_reg} : 32'h0;

`ifndef NO_ASSERTIONS
    // run count never passes the saturation limit
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_SAMPLES))
        else $error("run count above limit");

    // a result word always carries at least one point
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[44:34] != '0))
        else $error("empty run emitted");

    // in the cycle after accepting a sample the input side is closed
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_axis_tready)
        else $error("sample accepted while busy");

    // the divider is only started when it is idle
    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider restarted while busy");
`endif

endmodule
`default_nettype wire

/* test/scan_segment_centroid_core_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scan_segment_centroid_core_checker
// watches the sample and centroid streams and the config port, predicts
// each run's centroid and compares it with the words the core emits
// ----------------------------------------------------------------------------
module scan_segment_centroid_core_checker
    import ssc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,
    input  wire logic [0:0]  s_axis_tuser,
    input  wire logic        s_axis_tlast,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [47:0] m_axis_tdata,
    input  wire logic        m_axis_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    output int               fail_count,
    output int               centroid_count,
    output int               pending_count
);

    typedef struct packed {
        logic [16:0] mean_x;
        logic [16:0] mean_y;
        logic [10:0] point_count;
        logic        closes_scan;
    } centroid_t;

    centroid_t     centroid_q[$];
    logic   [15:0] step_reg;
    logic   [10:0] index_reg;
    longint        acc_x;
    longint        acc_y;
    int            pts;

    longint atan_tab[CORDIC_STEPS] = '{8192, 4836, 2555, 1297, 651, 326, 163,
                                       81, 41, 20, 10, 5, 3, 1};

    assign pending_count = centroid_q.size();

    // arithmetic shift floors, which is what the rounding needs
    function automatic longint q15_clamp(input longint v);
        longint r;
        r = (v + 16384) >>> 15;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r;
    endfunction

    function automatic void angle_to_trig(input logic [15:0] ang,
                                          output longint c, output longint s);
        longint x, y, z, dx, dy, cc, ss;
        x = 652032874;
        y = 0;
        z = ang[13:0];
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx; y = y + dy; z = z - atan_tab[i];
            end
            else
            begin
                x = x + dx; y = y - dy; z = z + atan_tab[i];
            end
        end
        cc = q15_clamp(x);
        ss = q15_clamp(y);
        case (ang[15:14])
            2'd0: begin c = cc;  s = ss;  end
            2'd1: begin c = -ss; s = cc;  end
            2'd2: begin c = -cc; s = -ss; end
            default: begin c = ss; s = -cc; end
        endcase
    endfunction

    function automatic longint mean_of(input longint sum, input int n);
        longint m;
        m = sum < 0 ? -sum : sum;
        m = (m + n / 2) / n;
        return sum < 0 ? -m : m;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        longint c, s;
        centroid_t exp_w, got_w;
        if (!rst_n)
        begin
            step_reg  = ANGLE_STEP_RESET;
            index_reg = '0;
            acc_x     = 0;
            acc_y     = 0;
            pts       = 0;
            centroid_q.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr[2] == REG_ANGLE_STEP)
                step_reg = pwdata[15:0];
            // centroid side first: a word cannot depend on a sample of this edge
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_w = {m_axis_tdata[16:0], m_axis_tdata[33:17],
                         m_axis_tdata[44:34], m_axis_tlast};
                centroid_count++;
                if (centroid_q.size() == 0)
                    report("unexpected centroid word", centroid_count, 0);
                else
                begin
                    exp_w = centroid_q.pop_front();
                    if (got_w.mean_x != exp_w.mean_x)
                        report("mean_x", $signed(got_w.mean_x), $signed(exp_w.mean_x));
                    if (got_w.mean_y != exp_w.mean_y)
                        report("mean_y", $signed(got_w.mean_y), $signed(exp_w.mean_y));
                    if (got_w.point_count != exp_w.point_count)
                        report("point_count", got_w.point_count, exp_w.point_count);
                    if (got_w.closes_scan != exp_w.closes_scan)
                        report("closes_scan", got_w.closes_scan, exp_w.closes_scan);
                    if (m_axis_tdata[47:45] != 3'd0)
                        report("pad bits", m_axis_tdata[47:45], 0);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser[0] && pts < MAX_SAMPLES)
                begin
                    angle_to_trig(16'(step_reg * index_reg), c, s);
                    acc_x += (longint'(s_axis_tdata) * c + 16384) >>> 15;
                    acc_y += (longint'(s_axis_tdata) * s + 16384) >>> 15;
                    pts++;
                end
                if ((!s_axis_tuser[0] || s_axis_tlast) && pts > 0)
                begin
                    exp_w.mean_x      = 17'(mean_of(acc_x, pts));
                    exp_w.mean_y      = 17'(mean_of(acc_y, pts));
                    exp_w.point_count = 11'(pts);
                    exp_w.closes_scan = s_axis_tlast;
                    centroid_q        = {centroid_q, exp_w};
                    acc_x = 0;
                    acc_y = 0;
                    pts   = 0;
                end
                index_reg = s_axis_tlast ? 11'd0 : index_reg + 11'd1;
            end
        end
    end

endmodule

/* test/scan_segment_centroid_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scan_segment_centroid_core_tb
// drives range samples and angle step writes into the core; the checker
// beside it predicts every centroid word and counts mismatches
// ----------------------------------------------------------------------------
module scan_segment_centroid_core_tb;
    import ssc_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [15:0] range_mm
    logic [0:0]  s_axis_tuser;   // [0] range_valid
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // [16:0] mean_x, [33:17] mean_y, [44:34] point_count
    logic        m_axis_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int centroid_count;
    int pending_count;
    int sample_count;
    bit calm;          // no idling in the last part
    bit hold_sink;     // long receiver hold-off

    scan_segment_centroid_core i_dut (.*);

    scan_segment_centroid_core_checker i_chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // generous limit on the run time of the whole regression
    initial
    begin
        #20ms;
        $display("scan_segment_centroid_core regression: fail");
        $finish;
    end

    // receiver: random stall bursts, plus one long hold-off on request
    initial
    begin
        int gap;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_sink)
            begin
                m_axis_tready = 1'b0;
                repeat (600) @(negedge clk);
                hold_sink = 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 14);
                m_axis_tready = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            else
                m_axis_tready = 1'b1;
        end
    end

    task automatic write_step(input logic [15:0] val);
        @(negedge clk);
        psel = 1'b1; pwrite = 1'b1; paddr = 3'd0; pwdata = {16'd0, val};
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    // wait until every expected word is in and the core has gone quiet
    task automatic drain();
        while (pending_count != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    // one sample word; optional idle before it
    task automatic send_sample(input logic [15:0] rng, input bit ok, input bit lst);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 14);
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = rng;
        s_axis_tuser  = ok;
        s_axis_tlast  = lst;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        sample_count++;
    endtask

    // a scan of n samples with short invalid gaps between runs
    task automatic send_scan(input int n, input int hole_odds);
        for (int i = 0; i < n; i++)
            send_sample(16'($urandom), $urandom_range(0, hole_odds) != 0, i == n - 1);
    endtask

    logic [15:0] step_set[6] = '{16'd0, 16'd65535, 16'd91, 16'd16384, 16'd1, 16'd2000};

    initial
    begin
        rst_n = 1'b0; s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = '0;
        s_axis_tlast = 1'b0; psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        paddr = '0; pwdata = '0; calm = 1'b0; hold_sink = 1'b0; sample_count = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // directed: reset step, field extremes, empty runs, invalid last
        send_sample(16'hffff, 1, 0);
        send_sample(16'h0000, 1, 0);
        send_sample(16'h0000, 0, 0);   // closes the run
        send_sample(16'h1234, 0, 0);   // empty run
        send_sample(16'hffff, 1, 0);
        send_sample(16'h8000, 0, 1);   // invalid last closes pending run
        send_sample(16'h0001, 0, 1);   // empty last
        send_sample(16'hffff, 1, 1);   // one-point run closed by last
        drain();
        // quadrant steps with full-scale range
        write_step(16'd16384);
        for (int i = 0; i < 5; i++)
            send_sample(16'hffff, 1, 0);
        send_sample(16'hffff, 1, 1);
        drain();

        // back pressure: receiver holds off while samples keep coming
        hold_sink = 1'b1;
        for (int i = 0; i < 40; i++)
            send_sample(16'($urandom), i % 2, 0);
        send_scan(10, 3);
        drain();

        // random phases across step settings; the last one runs with no idling
        foreach (step_set[k])
        begin
            write_step(k == 5 ? 16'($urandom) : step_set[k]);
            if (k == 5)
                calm = 1'b1;
            for (int j = 0; j < 9; j++)
                send_scan($urandom_range(1, 32), j < 7 ? 4 : 1);
            drain();
        end

        $display("covered %0d samples in %0d centroid words, incl. empty runs,",
                 sample_count, centroid_count);
        $display("invalid last marks, receiver hold-off and six angle step settings");
        if (fail_count == 0)
            $display("scan_segment_centroid_core regression: pass");
        else
            $display("scan_segment_centroid_core regression: fail");
        $finish;
    end

endmodule
